/* sv/sensor_batch_frame_encoder_assert.svh */
// Assertion macros for the frame encoder. Each one checks an implication on the rising
// clock edge and stays quiet while reset is high. Synthesis sees empty bodies.
`ifndef SENSOR_BATCH_FRAME_ENCODER_ASSERT_SVH
`define SENSOR_BATCH_FRAME_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define SBFE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sensor_batch_frame_encoder: implication check failed");
`define SBFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sensor_batch_frame_encoder: next-cycle check failed");
`else
`define SBFE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SBFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/sbfe_pkg.sv */
package sbfe_pkg;

   localparam int DEF_MAX_FRAME_BYTES = 512;
   localparam int DEF_MAX_RECORDS     = 255;
   localparam int DEF_MOTION_AXES     = 3;

   localparam int HEADER_BYTES = 16;
   localparam int MAX_AXES     = 3;
   localparam int MAX_WORDS    = 2 * MAX_AXES;
   localparam int WORD_IDX_W   = $clog2(MAX_WORDS);

   // A temperature gap of 65536 ms or more closes the frame.
   localparam logic [25:0] TEMP_GAP_LIMIT = 26'd65536000;
   // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every x below 2**26.
   localparam logic [26:0] MS_RECIP = 27'd68719477;
   localparam int          MS_SHIFT = 36;

   typedef enum logic [1:0] {
      CSR_STREAM_KIND    = 2'd0,
      CSR_FRAME_CAPACITY = 2'd1,
      CSR_MOTION_CODE    = 2'd2,
      CSR_TEMP_CODE      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  count;
      logic [31:0] first_seq;
      logic [63:0] base_time;
      logic [15:0] dropped;
      logic [9:0]  length;
   } hdr_type;

   typedef struct packed {
      logic                            hdr_a_en;
      hdr_type                         hdr_a;
      logic                            rec_en;
      logic                            kind;
      logic [9:0]                      start;
      logic [25:0]                     diff;
      logic [MAX_WORDS-1:0][15:0]      words;
      logic                            hdr_b_en;
      hdr_type                         hdr_b;
   } plan_type;

   function automatic logic [4:0] rec_len(input logic kind, input int axes);
      return kind ? 5'd6 : 5'(2 + 4 * axes);
   endfunction

   function automatic logic [7:0] hdr_byte(input hdr_type h, input logic [3:0] k,
                                           input logic [7:0] code);
      logic [7:0] b;
      case (k) inside
         4'd0:          b = code;
         4'd1:          b = h.count;
         [4'd2:4'd5]:   b = h.first_seq[{k[1:0] - 2'd2, 3'b000} +: 8];
         [4'd6:4'd13]:  b = h.base_time[{k[2:0] - 3'd6, 3'b000} +: 8];
         4'd14:         b = h.dropped[7:0];
         default:       b = h.dropped[15:8];
      endcase
      return b;
   endfunction

endpackage

/* sv/sbfe_serializer.sv */
module sbfe_serializer #(
   parameter int MOTION_AXES = sbfe_pkg::DEF_MOTION_AXES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              plan_valid,
   input  sbfe_pkg::plan_type plan,
   output logic              plan_ready,
   input  logic [7:0]        motion_code,
   input  logic [7:0]        temp_code,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [8:0]        rsp_byte_offset,
   output logic [7:0]        rsp_byte_value,
   output logic              rsp_frame_end,
   output logic [9:0]        rsp_frame_length,
   output logic [7:0]        rsp_records_in_frame,
   output logic              rsp_last_of_item
);
   import sbfe_pkg::*;

   typedef enum logic [1:0] {PH_HDR_A, PH_REC, PH_HDR_B} phase_type;

   plan_type  plan_ff;
   phase_type phase_ff;
   logic      busy_ff;
   logic [4:0] idx_ff;

   hdr_type    hdr;
   logic [7:0] code;
   logic [4:0] len;
   logic [52:0] prod;
   logic [15:0] gap;
   logic [4:0]  rel;
   logic [15:0] word;
   logic [7:0]  rec_byte;
   logic        out_free;
   logic        is_last;
   logic        is_end;
   logic [8:0]  cur_off;
   logic [7:0]  cur_val;
   phase_type   first_phase;

   always_comb begin
      hdr  = (phase_ff == PH_HDR_A) ? plan_ff.hdr_a : plan_ff.hdr_b;
      code = hdr.kind ? temp_code : motion_code;
      len  = rec_len(plan_ff.kind, MOTION_AXES);
      prod = 53'(plan_ff.diff) * 53'(MS_RECIP);
      gap  = plan_ff.kind ? prod[MS_SHIFT +: 16] : plan_ff.diff[15:0];
      rel  = idx_ff - 5'd2;
      word = plan_ff.words[rel[WORD_IDX_W:1]];
      if (idx_ff == 5'd0) begin
         rec_byte = gap[7:0];
      end else if (idx_ff == 5'd1) begin
         rec_byte = gap[15:8];
      end else begin
         rec_byte = rel[0] ? word[15:8] : word[7:0];
      end

      unique case (phase_ff)
         PH_REC: begin
            cur_off = 9'(plan_ff.start + 10'(idx_ff));
            cur_val = rec_byte;
            is_end  = 1'b0;
            is_last = (idx_ff == len - 5'd1) && !plan_ff.hdr_b_en;
         end
         PH_HDR_A: begin
            cur_off = 9'(idx_ff);
            cur_val = hdr_byte(hdr, idx_ff[3:0], code);
            is_end  = (idx_ff == 5'(HEADER_BYTES - 1));
            is_last = is_end && !plan_ff.rec_en;
         end
         default: begin
            cur_off = 9'(idx_ff);
            cur_val = hdr_byte(hdr, idx_ff[3:0], code);
            is_end  = (idx_ff == 5'(HEADER_BYTES - 1));
            is_last = is_end;
         end
      endcase

      out_free    = !rsp_valid || rsp_ready;
      plan_ready  = !busy_ff || (out_free && is_last);
      first_phase = plan.hdr_a_en ? PH_HDR_A : PH_REC;
   end

   always_ff @(posedge clock) begin
      if (plan_valid && plan_ready) begin
         plan_ff <= plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         phase_ff  <= PH_HDR_A;
         idx_ff    <= 5'd0;
         rsp_valid <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid <= busy_ff;
         end
         if (busy_ff && out_free) begin
            rsp_byte_offset      <= cur_off;
            rsp_byte_value       <= cur_val;
            rsp_frame_end        <= is_end;
            rsp_frame_length     <= is_end ? hdr.length : 10'd0;
            rsp_records_in_frame <= is_end ? hdr.count : 8'd0;
            rsp_last_of_item     <= is_last;
            if (is_last) begin
               busy_ff <= 1'b0;
            end else if (phase_ff == PH_HDR_A && is_end) begin
               phase_ff <= PH_REC;
               idx_ff   <= 5'd0;
            end else if (phase_ff == PH_REC && idx_ff == len - 5'd1) begin
               phase_ff <= PH_HDR_B;
               idx_ff   <= 5'd0;
            end else begin
               idx_ff <= idx_ff + 5'd1;
            end
         end
         if (plan_valid && plan_ready) begin
            busy_ff  <= 1'b1;
            phase_ff <= first_phase;
            idx_ff   <= 5'd0;
         end
      end
   end

endmodule

/* sv/sensor_batch_frame_encoder.sv */
// Delta-timestamp batch framer for sensor samples.
// Samples arrive on the req_ channel (valid/ready), one record per transfer. Each sample
// produces its record bytes on the rsp_ channel, one byte per transfer, tagged with its
// offset in the frame; when a frame closes, its 16 header bytes go out at offsets 0..15
// with rsp_frame_end on the last one, before the record of a sample whose gap closes it
// and after the record that fills or ends it. rsp_last_of_item marks the final byte of a
// sample. Samples pass through the input register, the plan register and the output
// register, which sends one byte per cycle while the receiver is ready; a sample yields
// 14 bytes (motion) or 6 bytes (temperature), plus 16 bytes for each header it closes.
// A sample that the frame capacity cannot hold, and that closes no frame, produces
// nothing. One sample waits in the input register while the previous one is serialized.
// Reset clears the configuration to its defaults and leaves no frame open.
// When the receiver stalls, the current byte holds in the output register and the input
// side stops taking samples once both the serializer and the input register are full.
// The csr_ port writes the indexed register; write it only while the block is idle.
`include "sensor_batch_frame_encoder_assert.svh"
module sensor_batch_frame_encoder #(
   parameter int MAX_FRAME_BYTES = sbfe_pkg::DEF_MAX_FRAME_BYTES,
   parameter int MAX_RECORDS     = sbfe_pkg::DEF_MAX_RECORDS,
   parameter int MOTION_AXES     = sbfe_pkg::DEF_MOTION_AXES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [9:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [63:0]        req_time_us,
   input  logic [31:0]        req_sequence_number,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic signed [31:0] req_milli_celsius,
   input  logic [31:0]        req_dropped_count,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [8:0]         rsp_byte_offset,
   output logic [7:0]         rsp_byte_value,
   output logic               rsp_frame_end,
   output logic [9:0]         rsp_frame_length,
   output logic [7:0]         rsp_records_in_frame,
   output logic               rsp_last_of_item
);
   import sbfe_pkg::*;

   typedef struct packed {
      logic [63:0]               time_us;
      logic [31:0]               seq;
      logic [MAX_AXES-1:0][15:0] accel;
      logic [MAX_AXES-1:0][15:0] gyro;
      logic [31:0]               milli_celsius;
      logic [31:0]               dropped;
      logic                      last_sample;
   } item_type;

   // Configuration registers.
   logic       stream_kind_ff;
   logic [9:0] frame_capacity_ff;
   logic [7:0] motion_code_ff;
   logic [7:0] temp_code_ff;

   // Frame state.
   logic        open_ff;
   logic [7:0]  count_ff;
   logic [63:0] base_ff;
   logic [63:0] prev_ff;
   logic [31:0] seq_ff;
   logic [31:0] drop_ff;
   logic [9:0]  woff_ff;
   logic        kind_ff;
   logic [9:0]  cap_ff;

   item_type item_ff;
   logic     in_valid_ff;

   logic [63:0] diff;
   logic        gap_close;
   logic        cont;
   logic [9:0]  cap_now;
   logic        fits;
   logic        rec_en;
   logic        r_kind;
   logic [9:0]  r_cap;
   logic [9:0]  r_start;
   logic [7:0]  r_count0;
   logic [63:0] r_base;
   logic [31:0] r_seq;
   logic [31:0] r_drop;
   logic [4:0]  r_len;
   logic [9:0]  end_off;
   logic [7:0]  count1;
   logic        close_b;
   plan_type    plan;
   logic        plan_valid;
   logic        plan_ready;
   logic        consume;

   function automatic logic [15:0] sat16(input logic [31:0] v);
      return (|v[31:16]) ? 16'hFFFF : v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_kind_ff    <= 1'b0;
         frame_capacity_ff <= 10'd244;
         motion_code_ff    <= 8'd1;
         temp_code_ff      <= 8'd2;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STREAM_KIND:    stream_kind_ff    <= csr_write_data[0];
            CSR_FRAME_CAPACITY: frame_capacity_ff <= csr_write_data;
            CSR_MOTION_CODE:    motion_code_ff    <= csr_write_data[7:0];
            CSR_TEMP_CODE:      temp_code_ff      <= csr_write_data[7:0];
         endcase
      end
   end

   always_comb begin
      diff = item_ff.time_us - prev_ff;
      // The temperature gap is compared before dividing, so the divide only ever sees
      // values below 2**26.
      gap_close = open_ff && (kind_ff ? ((|diff[63:26]) || (diff[25:0] >= TEMP_GAP_LIMIT))
                                      : (|diff[63:16]));
      cont    = open_ff && !gap_close;
      cap_now = (32'(frame_capacity_ff) > MAX_FRAME_BYTES) ? 10'(MAX_FRAME_BYTES)
                                                            : frame_capacity_ff;
      fits    = ({1'b0, cap_now} >=
                 11'(HEADER_BYTES) + 11'(rec_len(stream_kind_ff, MOTION_AXES)));
      rec_en  = cont || fits;

      r_kind   = cont ? kind_ff : stream_kind_ff;
      r_cap    = cont ? cap_ff : cap_now;
      r_start  = cont ? woff_ff : 10'(HEADER_BYTES);
      r_count0 = cont ? count_ff : 8'd0;
      r_base   = cont ? base_ff : item_ff.time_us;
      r_seq    = cont ? seq_ff : item_ff.seq;
      r_drop   = cont ? drop_ff : item_ff.dropped;
      r_len    = rec_len(r_kind, MOTION_AXES);
      end_off  = r_start + 10'(r_len);
      count1   = r_count0 + 8'd1;
      // Close at MAX_RECORDS, on the last sample, or when a further record would not fit.
      close_b  = (32'(count1) >= MAX_RECORDS) ||
                 ({1'b0, end_off} + 11'(r_len) > {1'b0, r_cap}) ||
                 item_ff.last_sample;

      plan.hdr_a_en        = gap_close;
      plan.hdr_a.kind      = kind_ff;
      plan.hdr_a.count     = count_ff;
      plan.hdr_a.first_seq = seq_ff;
      plan.hdr_a.base_time = base_ff;
      plan.hdr_a.dropped   = sat16(drop_ff);
      plan.hdr_a.length    = woff_ff;
      plan.rec_en          = rec_en;
      plan.kind            = r_kind;
      plan.start           = r_start;
      plan.diff            = cont ? diff[25:0] : 26'd0;
      plan.words           = '0;
      if (r_kind) begin
         plan.words[0] = item_ff.milli_celsius[15:0];
         plan.words[1] = item_ff.milli_celsius[31:16];
      end else begin
         for (int j = 0; j < MOTION_AXES; j++) begin
            plan.words[j]               = item_ff.accel[j];
            plan.words[MOTION_AXES + j] = item_ff.gyro[j];
         end
      end
      plan.hdr_b_en        = rec_en && close_b;
      plan.hdr_b.kind      = r_kind;
      plan.hdr_b.count     = count1;
      plan.hdr_b.first_seq = r_seq;
      plan.hdr_b.base_time = r_base;
      plan.hdr_b.dropped   = sat16(r_drop);
      plan.hdr_b.length    = end_off;

      plan_valid = in_valid_ff && (gap_close || rec_en);
      consume    = in_valid_ff && plan_ready;
      req_ready  = !in_valid_ff || consume;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.time_us       <= req_time_us;
         item_ff.seq           <= req_sequence_number;
         item_ff.accel         <= {req_accel_z, req_accel_y, req_accel_x};
         item_ff.gyro          <= {req_gyro_z, req_gyro_y, req_gyro_x};
         item_ff.milli_celsius <= req_milli_celsius;
         item_ff.dropped       <= req_dropped_count;
         item_ff.last_sample   <= req_last_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         open_ff     <= 1'b0;
         count_ff    <= 8'd0;
         base_ff     <= 64'd0;
         prev_ff     <= 64'd0;
         seq_ff      <= 32'd0;
         drop_ff     <= 32'd0;
         woff_ff     <= 10'(HEADER_BYTES);
         kind_ff     <= 1'b0;
         cap_ff      <= 10'd0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
         if (consume) begin
            if (rec_en) begin
               open_ff  <= !close_b;
               count_ff <= close_b ? 8'd0 : count1;
               woff_ff  <= close_b ? 10'(HEADER_BYTES) : end_off;
               prev_ff  <= item_ff.time_us;
               base_ff  <= r_base;
               seq_ff   <= r_seq;
               drop_ff  <= r_drop;
               kind_ff  <= r_kind;
               cap_ff   <= r_cap;
            end else begin
               // The sample is dropped; any frame that was open has just closed.
               open_ff  <= 1'b0;
               count_ff <= 8'd0;
               woff_ff  <= 10'(HEADER_BYTES);
            end
         end
      end
   end

   sbfe_serializer #(
      .MOTION_AXES(MOTION_AXES)
   ) u_serializer (
      .clock               (clock),
      .reset               (reset),
      .plan_valid          (plan_valid),
      .plan                (plan),
      .plan_ready          (plan_ready),
      .motion_code         (motion_code_ff),
      .temp_code           (temp_code_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_byte_offset     (rsp_byte_offset),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_frame_end       (rsp_frame_end),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_records_in_frame(rsp_records_in_frame),
      .rsp_last_of_item    (rsp_last_of_item)
   );

   `SBFE_ASSERT_IMPLIES(a_open_within_cap, clock, reset, open_ff, woff_ff <= cap_ff)
   `SBFE_ASSERT_IMPLIES(a_closed_is_empty, clock, reset, !open_ff,
                        count_ff == 8'd0 && woff_ff == 10'(HEADER_BYTES))
   `SBFE_ASSERT_NEXT(a_prev_time_follows, clock, reset, consume && rec_en,
                     prev_ff == $past(item_ff.time_us))
   `SBFE_ASSERT_IMPLIES(a_len_only_at_end, clock, reset, rsp_valid && !rsp_frame_end,
                        rsp_frame_length == 10'd0 && rsp_records_in_frame == 8'd0)

endmodule

/* sim/tb_sensor_batch_frame_encoder.sv */
module tb_sensor_batch_frame_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import sbfe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          ITEMS_PER_PHASE = 41;
   localparam int          RANDOM_PHASES = 8;

   typedef enum logic {
      KIND_MOTION      = 1'b0,
      KIND_TEMPERATURE = 1'b1
   } stream_kind_e;

   typedef struct packed {
      logic [63:0]        time_us;
      logic [31:0]        seq_num;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic signed [31:0] milli_c;
      logic [31:0]        dropped;
      logic               last;
   } sample_t;

   typedef struct packed {
      logic [8:0] offset;
      logic [7:0] value;
      logic       frame_end;
      logic [9:0] length;
      logic [7:0] records;
      logic       last;
   } frame_byte_t;

   // Tracks the framing state of the block and the bytes it still owes us.
   class frame_byte_checker;
      stream_kind_e kind_cfg;
      logic [9:0]   capacity_cfg;
      logic [7:0]   motion_code;
      logic [7:0]   temp_code;

      logic         frame_open;
      stream_kind_e frame_kind;
      int           frame_limit;
      logic [7:0]   record_count;
      logic [63:0]  base_time;
      logic [63:0]  prev_time;
      logic [31:0]  first_seq;
      logic [31:0]  dropped_latched;
      logic [9:0]   write_offset;

      frame_byte_t  bytes_due[$];
      int           error_count;

      function new();
         kind_cfg = KIND_MOTION;
         capacity_cfg = 10'd244;
         motion_code = 8'd1;
         temp_code = 8'd2;
         frame_open = 1'b0;
         frame_kind = KIND_MOTION;
         frame_limit = 0;
         record_count = '0;
         base_time = '0;
         prev_time = '0;
         first_seq = '0;
         dropped_latched = '0;
         write_offset = 10'(HEADER_BYTES);
         error_count = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [9:0] data);
         case (idx)
            CSR_STREAM_KIND:    kind_cfg = stream_kind_e'(data[0]);
            CSR_FRAME_CAPACITY: capacity_cfg = data;
            CSR_MOTION_CODE:    motion_code = data[7:0];
            CSR_TEMP_CODE:      temp_code = data[7:0];
            default: ;
         endcase
      endfunction

      function void push_byte(logic [9:0] offset, logic [7:0] value, logic is_end);
         frame_byte_t b;
         b.offset = offset[8:0];
         b.value = value;
         b.frame_end = is_end;
         b.length = is_end ? write_offset : 10'd0;
         b.records = is_end ? record_count : 8'd0;
         b.last = 1'b0;
         bytes_due.push_back(b);
      endfunction

      function void put_le(logic [63:0] v, int count);
         for (int k = 0; k < count; k++) begin
            push_byte(write_offset, v[8*k +: 8], 1'b0);
            write_offset++;
         end
      endfunction

      function void close_frame();
         logic [7:0]  header [HEADER_BYTES];
         logic [15:0] drop_sat;
         drop_sat = (dropped_latched > 32'hFFFF) ? 16'hFFFF : dropped_latched[15:0];
         header[0] = (frame_kind == KIND_TEMPERATURE) ? temp_code : motion_code;
         header[1] = record_count;
         for (int k = 0; k < 4; k++)
            header[2 + k] = first_seq[8*k +: 8];
         for (int k = 0; k < 8; k++)
            header[6 + k] = base_time[8*k +: 8];
         header[14] = drop_sat[7:0];
         header[15] = drop_sat[15:8];
         for (int k = 0; k < HEADER_BYTES; k++)
            push_byte(10'(k), header[k], k == HEADER_BYTES - 1);
         frame_open = 1'b0;
         record_count = '0;
         write_offset = 10'(HEADER_BYTES);
      endfunction

      function void mark_last(int first_new);
         if (bytes_due.size() > first_new)
            bytes_due[bytes_due.size() - 1].last = 1'b1;
      endfunction

      function void take_sample(sample_t s);
         logic [63:0] gap;
         int          rec_bytes;
         int          cap;
         int          first_new;
         first_new = bytes_due.size();
         gap = '0;
         if (frame_open) begin
            gap = s.time_us - prev_time;
            if (frame_kind == KIND_TEMPERATURE)
               gap = gap / 64'd1000;
            // An oversized gap closes the frame before this sample is placed.
            if (gap > 64'd65535) begin
               close_frame();
               gap = '0;
            end
         end
         if (!frame_open) begin
            rec_bytes = (kind_cfg == KIND_TEMPERATURE) ? 6 : 2 + 4 * DEF_MOTION_AXES;
            cap = (capacity_cfg > DEF_MAX_FRAME_BYTES) ? DEF_MAX_FRAME_BYTES
                                                       : int'(capacity_cfg);
            // Not even one record fits: the sample is lost.
            if (cap < HEADER_BYTES + rec_bytes) begin
               mark_last(first_new);
               return;
            end
            frame_limit = (cap - HEADER_BYTES) / rec_bytes;
            if (frame_limit > DEF_MAX_RECORDS)
               frame_limit = DEF_MAX_RECORDS;
            frame_kind = kind_cfg;
            frame_open = 1'b1;
            record_count = '0;
            write_offset = 10'(HEADER_BYTES);
            base_time = s.time_us;
            first_seq = s.seq_num;
            dropped_latched = s.dropped;
         end
         put_le(gap, 2);
         if (frame_kind == KIND_TEMPERATURE) begin
            put_le({32'd0, s.milli_c}, 4);
         end else begin
            put_le({48'd0, s.accel_x}, 2);
            put_le({48'd0, s.accel_y}, 2);
            put_le({48'd0, s.accel_z}, 2);
            put_le({48'd0, s.gyro_x}, 2);
            put_le({48'd0, s.gyro_y}, 2);
            put_le({48'd0, s.gyro_z}, 2);
         end
         prev_time = s.time_us;
         record_count++;
         if (record_count >= frame_limit || s.last)
            close_frame();
         mark_last(first_new);
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      task check_byte(frame_byte_t got);
         frame_byte_t want;
         if (bytes_due.size() == 0) begin
            report($sformatf("unexpected byte, offset %0d value %02h", got.offset, got.value));
            return;
         end
         want = bytes_due.pop_front();
         if (got.offset !== want.offset)
            report($sformatf("byte_offset got %0d expected %0d", got.offset, want.offset));
         if (got.value !== want.value)
            report($sformatf("byte_value at offset %0d got %02h expected %02h",
                             want.offset, got.value, want.value));
         if (got.frame_end !== want.frame_end)
            report($sformatf("frame_end at offset %0d got %b expected %b",
                             want.offset, got.frame_end, want.frame_end));
         if (got.length !== want.length)
            report($sformatf("frame_length got %0d expected %0d", got.length, want.length));
         if (got.records !== want.records)
            report($sformatf("records_in_frame got %0d expected %0d",
                             got.records, want.records));
         if (got.last !== want.last)
            report($sformatf("last_of_item at offset %0d got %b expected %b",
                             want.offset, got.last, want.last));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [9:0]         csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [63:0]        req_time_us = '0;
   logic [31:0]        req_sequence_number = '0;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic signed [15:0] req_gyro_x = '0;
   logic signed [15:0] req_gyro_y = '0;
   logic signed [15:0] req_gyro_z = '0;
   logic signed [31:0] req_milli_celsius = '0;
   logic [31:0]        req_dropped_count = '0;
   logic               req_last_sample = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [8:0]         rsp_byte_offset;
   logic [7:0]         rsp_byte_value;
   logic               rsp_frame_end;
   logic [9:0]         rsp_frame_length;
   logic [7:0]         rsp_records_in_frame;
   logic               rsp_last_of_item;

   frame_byte_checker tracker;
   int unsigned       cycle_count = 0;
   bit                sender_idles = 1'b1;
   bit                receiver_stalls = 1'b1;
   int                stall_left = 0;
   logic [63:0]       next_time = '0;
   logic [31:0]       next_seq = '0;

   sensor_batch_frame_encoder dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_time_us          (req_time_us),
      .req_sequence_number  (req_sequence_number),
      .req_accel_x          (req_accel_x),
      .req_accel_y          (req_accel_y),
      .req_accel_z          (req_accel_z),
      .req_gyro_x           (req_gyro_x),
      .req_gyro_y           (req_gyro_y),
      .req_gyro_z           (req_gyro_z),
      .req_milli_celsius    (req_milli_celsius),
      .req_dropped_count    (req_dropped_count),
      .req_last_sample      (req_last_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_byte_offset      (rsp_byte_offset),
      .rsp_byte_value       (rsp_byte_value),
      .rsp_frame_end        (rsp_frame_end),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_records_in_frame (rsp_records_in_frame),
      .rsp_last_of_item     (rsp_last_of_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver back-pressure: mostly ready, short stalls, now and then a long one.
   always @(posedge clock) begin
      int pick;
      if (!receiver_stalls) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left <= (pick < 95) ? $urandom_range(0, 2) : $urandom_range(15, 40);
         end
      end
   end

   always @(posedge clock) begin
      frame_byte_t got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.offset = rsp_byte_offset;
         got.value = rsp_byte_value;
         got.frame_end = rsp_frame_end;
         got.length = rsp_frame_length;
         got.records = rsp_records_in_frame;
         got.last = rsp_last_of_item;
         tracker.check_byte(got);
      end
   end

   function automatic int idle_cycles();
      int pick;
      if (!sender_idles)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic sample_t fixed_sample(logic [63:0] t, logic [31:0] seq,
                                            logic [15:0] word, logic [31:0] milli,
                                            logic [31:0] dropped, logic last);
      sample_t s;
      s.time_us = t;
      s.seq_num = seq;
      s.accel_x = word;
      s.accel_y = word;
      s.accel_z = word;
      s.gyro_x = ~word;
      s.gyro_y = ~word;
      s.gyro_z = ~word;
      s.milli_c = milli;
      s.dropped = dropped;
      s.last = last;
      return s;
   endfunction

   function automatic sample_t random_sample(int last_rate);
      sample_t s;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         next_time = next_time + $urandom_range(0, 4000);
      end else if (pick < 78) begin
         // Steps right at the motion and temperature gap limits.
         case ($urandom_range(0, 3))
            0:       next_time = next_time + 64'd65535;
            1:       next_time = next_time + 64'd65536;
            2:       next_time = next_time + 64'd65535999;
            default: next_time = next_time + 64'd65536000;
         endcase
      end else if (pick < 86) begin
         next_time = next_time + $urandom_range(0, 80_000_000);
      end else if (pick < 92) begin
         next_time = next_time - $urandom_range(1, 5000);
      end else begin
         next_time = {$urandom(), $urandom()};
      end
      next_seq = ($urandom_range(0, 99) < 85) ? next_seq + 1 : $urandom();
      s.time_us = next_time;
      s.seq_num = next_seq;
      s.accel_x = 16'($urandom());
      s.accel_y = 16'($urandom());
      s.accel_z = 16'($urandom());
      s.gyro_x = 16'($urandom());
      s.gyro_y = 16'($urandom());
      s.gyro_z = 16'($urandom());
      s.milli_c = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 70)
         s.dropped = $urandom_range(0, 300);
      else if (pick < 90)
         s.dropped = $urandom();
      else
         s.dropped = $urandom_range(65535, 65536);
      s.last = ($urandom_range(1, last_rate) == 1);
      return s;
   endfunction

   task automatic send(sample_t s);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_us <= s.time_us;
      req_sequence_number <= s.seq_num;
      req_accel_x <= s.accel_x;
      req_accel_y <= s.accel_y;
      req_accel_z <= s.accel_z;
      req_gyro_x <= s.gyro_x;
      req_gyro_y <= s.gyro_y;
      req_gyro_z <= s.gyro_z;
      req_milli_celsius <= s.milli_c;
      req_dropped_count <= s.dropped;
      req_last_sample <= s.last;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.take_sample(s);
   endtask

   // Stop sending until every byte owed has been transferred, then let the
   // block finish any sample that produces no bytes.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cfg(csr_index_type idx, logic [9:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic configure(stream_kind_e kind, logic [9:0] capacity,
                            logic [7:0] mcode, logic [7:0] tcode);
      write_cfg(CSR_STREAM_KIND, {9'd0, kind});
      write_cfg(CSR_FRAME_CAPACITY, capacity);
      write_cfg(CSR_MOTION_CODE, {2'd0, mcode});
      write_cfg(CSR_TEMP_CODE, {2'd0, tcode});
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [9:0] capacity;
      tracker = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Motion frames: gap limits, time running backwards, saturated drop count.
      configure(KIND_MOTION, 10'd512, 8'h00, 8'hFF);
      send(fixed_sample(64'd0, 32'd0, 16'h8000, 32'd0, 32'd0, 1'b0));
      send(fixed_sample(64'd65535, 32'hFFFF_FFFF, 16'h7FFF, 32'd0, 32'd1, 1'b0));
      send(fixed_sample(64'd131071, 32'd7, 16'h0000, 32'd0, 32'd65535, 1'b0));
      send(fixed_sample(64'd100, 32'd8, 16'hFFFF, 32'd0, 32'd65536, 1'b0));
      // Gap close, record, and last-sample close all from one transfer.
      send(fixed_sample(64'hFFFF_FFFF_FFFF_FFFF, 32'd9, 16'h5555, 32'd0,
                        32'hFFFF_FFFF, 1'b1));
      send(fixed_sample(64'd1000, 32'd10, 16'hAAAA, 32'd0, 32'd3, 1'b0));
      wait_idle();

      // Capacity too small for a motion record: the gap closes the open frame,
      // and neither that sample nor the next one can start a new frame.
      configure(KIND_MOTION, 10'd29, 8'h11, 8'h22);
      send(fixed_sample(64'd71000, 32'd11, 16'h1234, 32'd0, 32'd4, 1'b0));
      send(fixed_sample(64'd72000, 32'd12, 16'h4321, 32'd0, 32'd5, 1'b0));
      wait_idle();
      configure(KIND_TEMPERATURE, 10'd0, 8'h33, 8'h44);
      send(fixed_sample(64'd73000, 32'd13, 16'h0F0F, 32'd1, 32'd6, 1'b0));
      wait_idle();
      configure(KIND_TEMPERATURE, 10'd21, 8'h33, 8'h44);
      send(fixed_sample(64'd74000, 32'd14, 16'h0F0F, 32'd2, 32'd6, 1'b0));
      wait_idle();

      // One record per temperature frame at the smallest usable capacity.
      configure(KIND_TEMPERATURE, 10'd22, 8'h33, 8'h44);
      send(fixed_sample(64'd75000, 32'd15, 16'h0000, 32'h8000_0000, 32'd7, 1'b0));
      send(fixed_sample(64'd76000, 32'd16, 16'h0000, 32'h7FFF_FFFF, 32'd8, 1'b0));
      wait_idle();

      // Temperature gaps at the millisecond limit and going backwards.
      configure(KIND_TEMPERATURE, 10'd512, 8'hC3, 8'h5A);
      send(fixed_sample(64'd5_000_000, 32'd20, 16'h0000, 32'd0, 32'd9, 1'b0));
      send(fixed_sample(64'd70_535_999, 32'd21, 16'h0000, 32'd1000, 32'd9, 1'b0));
      send(fixed_sample(64'd136_071_999, 32'd22, 16'h0000, 32'd2000, 32'd9, 1'b0));
      send(fixed_sample(64'd136_071_000, 32'd23, 16'h0000, 32'd3000, 32'd9, 1'b0));
      send(fixed_sample(64'd136_071_999, 32'd24, 16'h0000, 32'd4000, 32'd9, 1'b1));
      send(fixed_sample(64'd136_080_000, 32'd25, 16'h0000, 32'd5000, 32'd9, 1'b0));
      wait_idle();

      // The open temperature frame keeps its kind after the switch to motion.
      configure(KIND_MOTION, 10'd30, 8'hA5, 8'h3C);
      send(fixed_sample(64'd136_081_000, 32'd26, 16'h0000, 32'd6000, 32'd9, 1'b1));
      send(fixed_sample(64'd136_082_000, 32'd27, 16'h3C3C, 32'd0, 32'd9, 1'b0));
      next_time = 64'd136_082_000;
      next_seq = 32'd27;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         case (p)
            0, 1:    capacity = 10'd512;
            2:       capacity = 10'd30;
            3:       capacity = 10'd22;
            4:       capacity = 10'd1023;
            5:       capacity = $urandom_range(22, 512);
            6:       capacity = $urandom_range(30, 512);
            default: capacity = $urandom_range(0, 1023);
         endcase
         configure(stream_kind_e'(p % 2), capacity,
                   (p == 0) ? 8'hFF : 8'($urandom()),
                   (p == 1) ? 8'h00 : 8'($urandom()));
         sender_idles = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2 && p % 3 == 1)
               wait_idle();
            send(random_sample((p % 2 == 1) ? 100 : 16));
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (tracker.error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
